@@ rtl/core/cht_pkg.sv @@
// Shared types, codes and constants of the chained hash table.
`default_nettype none

package cht_pkg;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_NULL_KEY  = 3'd3;
    localparam logic [2:0] STAT_NO_MEM    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_MAX_ENTRIES  = 1'b1;

    // Hash multiplier and divisor width (holds any bucket count up to 65536).
    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam int DIV_W = 17;
    localparam logic [DIV_W-1:0] DEFAULT_BUCKETS = 17'd509;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [63:0] value_in;
    } cht_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value_out;
        logic [8:0]  entry_count_out;
    } cht_out_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      key_lo;
        logic [DIV_W-1:0] divisor;
    } cht_hash_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] bucket;
    } cht_hash_rsp_t;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_CLEAR,
        FSM_HASH_GO,
        FSM_HASH_WAIT,
        FSM_HEAD_RD,
        FSM_HEAD_WT,
        FSM_WALK_RD,
        FSM_WALK_CMP,
        FSM_ALLOC_RD,
        FSM_ALLOC_WR,
        FSM_RESP
    } cht_state_t;

endpackage

`default_nettype wire

@@ rtl/core/chained_hash_table_top.sv @@
// Top level of the chained hash table: sequencer, table memories and register port.
`default_nettype none

// Key/value table with integer keys, one operation per input word and one result word
// per operation. A put, get or remove runs a bit-serial remainder of the hash by the
// bucket count, a bucket head lookup and the handshake, and for each node visited in
// the bucket chain one registered node memory read and one key compare. A clear
// sweeps the bucket head memory one bucket per cycle. After reset the same sweep runs
// over all NUM_BUCKETS buckets, during which no input word is taken; register writes
// are taken.
module chained_hash_table_top import cht_pkg::*; #(
    parameter int NUM_BUCKETS  = 512,
    parameter int POOL_ENTRIES = 256,
    parameter int DATA_WIDTH   = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire cht_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output cht_out_t         m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int NW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam logic [CW-1:0] NIL = CW'(POOL_ENTRIES);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

    // Configuration registers.
    logic [9:0] bucket_count_reg;
    logic [8:0] max_entries_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= 10'd509;
            max_entries_reg  <= 9'd0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_BUCKET_COUNT: bucket_count_reg <= pwdata[9:0];
                REG_MAX_ENTRIES:  max_entries_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BUCKET_COUNT: prdata = {22'd0, bucket_count_reg};
            REG_MAX_ENTRIES:  prdata = {23'd0, max_entries_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    cht_state_t            state_reg, state_next;
    logic [1:0]            mode_reg;
    logic [63:0]           key_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [BW-1:0]         bucket_reg;
    logic [CW-1:0]         cur_reg, prev_reg, head_reg;
    logic [CW-1:0]         steps_reg;
    logic [CW-1:0]         fill_reg, minfill_reg, count_reg;
    logic [BW-1:0]         clr_idx_reg;
    logic [2:0]            status_reg;
    logic [63:0]           vout_reg;

    // Memories and their registered read data.
    logic [CW-1:0]         bucket_mem [NUM_BUCKETS];
    logic [63:0]           key_mem    [POOL_ENTRIES];
    logic [DATA_WIDTH-1:0] val_mem    [POOL_ENTRIES];
    logic [CW-1:0]         next_mem   [POOL_ENTRIES];
    logic [NW-1:0]         free_mem   [POOL_ENTRIES];
    logic [CW-1:0]         head_q, next_q;
    logic [63:0]           key_q;
    logic [DATA_WIDTH-1:0] val_q;
    logic [NW-1:0]         free_q;

    // Hash unit.
    cht_hash_req_t hash_req;
    cht_hash_rsp_t hash_rsp;

    cht_hash_unit u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hash_req (hash_req),
        .hash_rsp (hash_rsp)
    );

    // Effective bucket count: zero selects the default, large values saturate.
    logic [DIV_W-1:0] div_raw, div_eff;

    always_comb begin
        div_raw = (bucket_count_reg == 10'd0) ? DEFAULT_BUCKETS : DIV_W'(bucket_count_reg);
        div_eff = (div_raw > DIV_W'(NUM_BUCKETS)) ? DIV_W'(NUM_BUCKETS) : div_raw;
    end

    assign hash_req.start   = (state_reg == FSM_HASH_GO);
    assign hash_req.key_lo  = key_reg[31:0];
    assign hash_req.divisor = div_eff;

    // Decisions shared by the sequencer and the datapath.
    logic          accept, is_full, walk_end, hit, sweep_last;
    logic [CW-1:0] fill_m1;
    logic [NW-1:0] new_node;

    always_comb begin
        accept     = s_valid && (state_reg == FSM_IDLE);
        is_full    = (max_entries_reg != 9'd0) && (17'(count_reg) >= 17'(max_entries_reg));
        walk_end   = (cur_reg == NIL) || (steps_reg == NIL);
        hit        = (key_q == key_reg);
        sweep_last = (clr_idx_reg == LAST_BUCKET);
        fill_m1    = fill_reg - CW'(1);
        // Stack slots below the low-water mark still hold their initial index.
        new_node   = (fill_m1 < minfill_reg) ? fill_m1[NW-1:0] : free_q;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_INIT: begin
                if (sweep_last) state_next = FSM_IDLE;
            end
            FSM_IDLE: begin
                if (accept) begin
                    if (s_data.mode == MODE_CLEAR) begin
                        state_next = FSM_CLEAR;
                    end else if (s_data.key == 64'd0) begin
                        state_next = FSM_RESP;
                    end else if (s_data.mode == MODE_PUT && is_full) begin
                        state_next = FSM_RESP;
                    end else begin
                        state_next = FSM_HASH_GO;
                    end
                end
            end
            FSM_CLEAR: begin
                if (sweep_last) state_next = FSM_RESP;
            end
            FSM_HASH_GO:   state_next = FSM_HASH_WAIT;
            FSM_HASH_WAIT: begin
                if (hash_rsp.done) state_next = FSM_HEAD_RD;
            end
            FSM_HEAD_RD:   state_next = FSM_HEAD_WT;
            FSM_HEAD_WT:   state_next = FSM_WALK_RD;
            FSM_WALK_RD: begin
                if (!walk_end) begin
                    state_next = FSM_WALK_CMP;
                end else if (mode_reg == MODE_PUT && fill_reg != '0) begin
                    state_next = FSM_ALLOC_RD;
                end else begin
                    state_next = FSM_RESP;
                end
            end
            FSM_WALK_CMP: state_next = hit ? FSM_RESP : FSM_WALK_RD;
            FSM_ALLOC_RD: state_next = FSM_ALLOC_WR;
            FSM_ALLOC_WR: state_next = FSM_RESP;
            FSM_RESP: begin
                if (m_ready) state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Memory write strobes.
    logic                  bucket_we, next_we, key_we, val_we, free_we;
    logic [BW-1:0]         bucket_waddr;
    logic [CW-1:0]         bucket_wdata, next_wdata;
    logic [NW-1:0]         next_waddr, node_waddr, val_waddr, free_waddr;

    always_comb begin
        bucket_we    = 1'b0;
        bucket_waddr = bucket_reg;
        bucket_wdata = NIL;
        next_we      = 1'b0;
        next_waddr   = new_node;
        next_wdata   = head_reg;
        key_we       = 1'b0;
        node_waddr   = new_node;
        val_we       = 1'b0;
        val_waddr    = new_node;
        free_we      = 1'b0;
        free_waddr   = fill_reg[NW-1:0];
        unique case (state_reg)
            FSM_INIT, FSM_CLEAR: begin
                bucket_we    = 1'b1;
                bucket_waddr = clr_idx_reg;
            end
            FSM_WALK_CMP: begin
                if (hit && mode_reg == MODE_PUT) begin
                    val_we    = 1'b1;
                    val_waddr = cur_reg[NW-1:0];
                end
                if (hit && mode_reg == MODE_REMOVE) begin
                    // Unlink from the predecessor or from the bucket head.
                    if (prev_reg != NIL) begin
                        next_we    = 1'b1;
                        next_waddr = prev_reg[NW-1:0];
                        next_wdata = next_q;
                    end else begin
                        bucket_we    = 1'b1;
                        bucket_wdata = next_q;
                    end
                    free_we = (fill_reg < NIL);
                end
            end
            FSM_ALLOC_WR: begin
                // New node goes to the head of its chain.
                key_we       = 1'b1;
                val_we       = 1'b1;
                next_we      = 1'b1;
                bucket_we    = 1'b1;
                bucket_wdata = CW'(new_node);
            end
            default: ;
        endcase
    end

    // Memory ports: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (bucket_we) bucket_mem[bucket_waddr] <= bucket_wdata;
        head_q <= bucket_mem[bucket_reg];
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[node_waddr] <= key_reg;
        key_q <= key_mem[cur_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (val_we) val_mem[val_waddr] <= val_reg;
        val_q <= val_mem[cur_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_waddr] <= next_wdata;
        next_q <= next_mem[cur_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (free_we) free_mem[free_waddr] <= cur_reg[NW-1:0];
        free_q <= free_mem[fill_m1[NW-1:0]];
    end

    // State register and control counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_INIT;
            clr_idx_reg <= '0;
            fill_reg    <= NIL;
            minfill_reg <= NIL;
            count_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                FSM_INIT, FSM_CLEAR: begin
                    clr_idx_reg <= sweep_last ? '0 : clr_idx_reg + BW'(1);
                    if (sweep_last) begin
                        fill_reg    <= NIL;
                        minfill_reg <= NIL;
                        count_reg   <= '0;
                    end
                end
                FSM_WALK_CMP: begin
                    if (hit && mode_reg == MODE_REMOVE) begin
                        if (fill_reg < NIL) fill_reg <= fill_reg + CW'(1);
                        if (count_reg != '0) count_reg <= count_reg - CW'(1);
                    end
                end
                FSM_ALLOC_WR: begin
                    fill_reg  <= fill_m1;
                    count_reg <= count_reg + CW'(1);
                    if (fill_m1 < minfill_reg) minfill_reg <= fill_m1;
                end
                default: ;
            endcase
        end
    end

    // Operation datapath.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    mode_reg   <= s_data.mode;
                    key_reg    <= s_data.key;
                    val_reg    <= s_data.value_in[DATA_WIDTH-1:0];
                    prev_reg   <= NIL;
                    steps_reg  <= '0;
                    vout_reg   <= 64'd0;
                    status_reg <= STAT_OK;
                    if (s_data.mode != MODE_CLEAR) begin
                        if (s_data.key == 64'd0) begin
                            status_reg <= STAT_NULL_KEY;
                        end else if (s_data.mode == MODE_PUT && is_full) begin
                            status_reg <= STAT_FULL;
                        end
                    end
                end
            end
            FSM_HASH_WAIT: begin
                if (hash_rsp.done) bucket_reg <= hash_rsp.bucket[BW-1:0];
            end
            FSM_HEAD_WT: begin
                cur_reg  <= head_q;
                head_reg <= head_q;
            end
            FSM_WALK_RD: begin
                if (walk_end) begin
                    if (mode_reg != MODE_PUT) begin
                        status_reg <= STAT_NOT_FOUND;
                    end else if (fill_reg == '0) begin
                        status_reg <= STAT_NO_MEM;
                    end
                end
            end
            FSM_WALK_CMP: begin
                if (hit) begin
                    if (mode_reg == MODE_GET) vout_reg <= 64'(val_q);
                end else begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= next_q;
                    steps_reg <= steps_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // Handshake and result word.
    assign s_ready                = (state_reg == FSM_IDLE);
    assign m_valid                = (state_reg == FSM_RESP);
    assign m_data.status          = status_reg;
    assign m_data.value_out       = vout_reg;
    assign m_data.entry_count_out = 9'(count_reg);

endmodule

`default_nettype wire

@@ rtl/core/cht_hash_unit.sv @@
// Multiplicative hash followed by a bit-serial remainder by the bucket count.
`default_nettype none

module cht_hash_unit import cht_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire cht_hash_req_t hash_req,
    output cht_hash_rsp_t      hash_rsp
);

    logic [31:0]      prod_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_sub;

    // One restoring remainder step: shift in the next hash bit, subtract if it fits.
    always_comb begin
        rem_shift = {rem_reg, prod_reg[31]};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (hash_req.start) begin
                // The product is truncated to its low 32 bits.
                prod_reg <= hash_req.key_lo * HASH_MULT;
                div_reg  <= hash_req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= 5'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= {prod_reg[30:0], 1'b0};
                if (rem_shift >= {1'b0, div_reg}) begin
                    rem_reg <= rem_sub[DIV_W-1:0];
                end else begin
                    rem_reg <= rem_shift[DIV_W-1:0];
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign hash_rsp.done   = done_reg;
    assign hash_rsp.bucket = rem_reg;

endmodule

`default_nettype wire
